// ===== rtl/core/ff4_pkg.sv =====
// ============================================================================
// ff4_pkg : shared types and constants for the 4-connected flood fill unit
// Frame geometry, stack sizing, command codes, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package ff4_pkg;

    // Frame geometry (pixel index = y * FRAME_WIDTH + x)
    localparam int FRAME_WIDTH  = 256;
    localparam int FRAME_HEIGHT = 256;
    localparam int FRAME_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int XW           = 8;
    localparam int YW           = 8;
    localparam int ADDR_W       = $clog2(FRAME_SIZE);

    // Seed stack sizing; pointer holds 0..STACK_DEPTH
    localparam int STACK_DEPTH  = 65536;
    localparam int STK_AW       = $clog2(STACK_DEPTH);
    localparam int SP_W         = $clog2(STACK_DEPTH + 1);

    // Pixel color and result widths
    localparam int COLOR_W      = 24;
    localparam int CNT_W        = 17;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Configuration registers
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL   = 1'd1;
    localparam logic [COLOR_W-1:0] TARGET_RESET = 24'hFF0000;
    localparam logic [COLOR_W-1:0] FILL_RESET   = 24'h0000FF;

    // Command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Neighbour visit order
    typedef enum logic [1:0] {
        NB_RIGHT = 2'd0,
        NB_LEFT  = 2'd1,
        NB_DOWN  = 2'd2,
        NB_UP    = 2'd3
    } nbr_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ_WAIT,
        ST_SEED_CHK,
        ST_POP,
        ST_NB_RD,
        ST_NB_CHK
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic latch;       // capture the command beat
        logic pix_wr_in;   // store pixel_value at the command address
        logic pix_rd_in;   // read pixel at the command address
        logic pix_rd_nb;   // read pixel at the current neighbour
        logic paint_seed;  // paint and push the seed, restart count
        logic paint_nb;    // paint and push the current neighbour
        logic pop;         // pop one stack entry
        logic nb_clr;      // restart the neighbour walk
        logic nb_inc;      // step to the next neighbour
        logic res_read;    // issue a read result
        logic res_fill;    // issue a fill result
        logic res_zero;    // issue an all-zero result
    } ff4_ctrl_t;

    // Datapath -> controller status
    typedef struct packed {
        cmd_t cmd;
        logic in_frame;      // command coordinate within the frame
        logic colors_equal;  // fill color equals target color
        logic pix_match;     // last pixel read equals target color
        logic nb_valid;      // current neighbour within the frame
        logic nb_last;       // current neighbour is the last one
        logic sp_zero;
        logic sp_full;
    } ff4_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ff4_ctrl.sv =====
// ============================================================================
// ff4_ctrl : command sequencer for the flood fill unit
// Decodes each command beat and steps the datapath through pixel access,
// seed check, stack pops and the four-neighbour walk of a fill.
// ============================================================================
`default_nettype none

module ff4_ctrl
    import ff4_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire ff4_stat_t stat,
    output ff4_ctrl_t      ctl
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_READ:
                    begin
                        state_next = stat.in_frame ? ST_READ_WAIT : ST_IDLE;
                    end
                    CMD_FILL:
                    begin
                        state_next = (stat.in_frame && !stat.colors_equal) ? ST_SEED_CHK
                                                                           : ST_IDLE;
                    end
                    CMD_WRITE, CMD_NOP:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_SEED_CHK:
            begin
                state_next = stat.pix_match ? ST_POP : ST_IDLE;
            end
            ST_POP:
            begin
                state_next = stat.sp_zero ? ST_IDLE : ST_NB_RD;
            end
            ST_NB_RD:
            begin
                priority if (stat.nb_valid)
                begin
                    state_next = ST_NB_CHK;
                end
                else if (stat.nb_last)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_NB_RD;
                end
            end
            ST_NB_CHK:
            begin
                state_next = stat.nb_last ? ST_POP : ST_NB_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl  = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.latch = start;
            end
            ST_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_WRITE:
                    begin
                        ctl.pix_wr_in = 1'b1;
                        ctl.res_zero  = 1'b1;
                    end
                    CMD_READ:
                    begin
                        ctl.pix_rd_in = stat.in_frame;
                        ctl.res_zero  = !stat.in_frame;
                    end
                    CMD_FILL:
                    begin
                        ctl.pix_rd_in = stat.in_frame && !stat.colors_equal;
                        ctl.res_zero  = !(stat.in_frame && !stat.colors_equal);
                    end
                    CMD_NOP:
                    begin
                        ctl.res_zero = 1'b1;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                ctl.res_read = 1'b1;
            end
            ST_SEED_CHK:
            begin
                ctl.paint_seed = stat.pix_match;
                ctl.res_zero   = !stat.pix_match;
            end
            ST_POP:
            begin
                ctl.res_fill = stat.sp_zero;
                ctl.pop      = !stat.sp_zero;
                ctl.nb_clr   = !stat.sp_zero;
            end
            ST_NB_RD:
            begin
                ctl.pix_rd_nb = stat.nb_valid;
                ctl.nb_inc    = !stat.nb_valid && !stat.nb_last;
            end
            ST_NB_CHK:
            begin
                ctl.paint_nb = stat.pix_match && !stat.sp_full;
                ctl.nb_inc   = !stat.nb_last;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/ff4_datapath.sv =====
// ============================================================================
// ff4_datapath : frame store, seed stack and counters of the flood fill unit
// Holds the pixel memory and coordinate stack (one access each per cycle,
// registered read data), color registers, neighbour walk and result registers.
// ============================================================================
`default_nettype none

module ff4_datapath
    import ff4_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // command beat
    input  wire logic [1:0]           cmd,
    input  wire logic [XW-1:0]        x_coord,
    input  wire logic [YW-1:0]        y_coord,
    input  wire logic [COLOR_W-1:0]   pixel_value,
    // configuration
    input  wire logic                 cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    // sequencer link
    input  wire ff4_ctrl_t            ctl,
    output ff4_stat_t                 stat,
    // result
    output logic                      done,
    output logic [COLOR_W-1:0]        read_value,
    output logic [CNT_W-1:0]          fill_count
);

    // Pixel index from zero-extended coordinates
    function automatic logic [ADDR_W-1:0] pix_index(input logic [XW:0] px,
                                                    input logic [YW:0] py);
        return ADDR_W'(int'(py) * FRAME_WIDTH + int'(px));
    endfunction

    // Storage
    logic [COLOR_W-1:0] frame_mem [FRAME_SIZE];
    logic [ADDR_W-1:0]  stack_mem [STACK_DEPTH];
    logic [COLOR_W-1:0] frame_q_reg;
    logic [ADDR_W-1:0]  stack_q_reg;

    // Registers
    cmd_t               cmd_reg;
    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic [COLOR_W-1:0] pv_reg;
    logic [COLOR_W-1:0] target_reg;
    logic [COLOR_W-1:0] fill_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [SP_W-1:0]    sp_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    nbr_t               nb_reg;
    nbr_t               nb_next;
    logic               done_reg;
    logic [COLOR_W-1:0] rv_reg;
    logic [CNT_W-1:0]   fc_reg;

    // Address and neighbour logic
    logic [ADDR_W-1:0]  in_addr;
    logic [XW-1:0]      cx;
    logic [YW-1:0]      cy;
    logic [XW:0]        nx;
    logic [YW:0]        ny;
    logic               nb_valid;
    logic [ADDR_W-1:0]  nb_addr;
    logic [SP_W-1:0]    sp_dec;
    logic               pix_we;
    logic [ADDR_W-1:0]  pix_waddr;
    logic [COLOR_W-1:0] pix_wdata;
    logic               pix_re;
    logic [ADDR_W-1:0]  pix_raddr;
    logic               push;
    logic [ADDR_W-1:0]  push_data;
    logic               in_frame;

    assign in_frame = (int'(x_reg) < FRAME_WIDTH) && (int'(y_reg) < FRAME_HEIGHT);
    assign in_addr  = pix_index({1'b0, x_reg}, {1'b0, y_reg});

    // Split the popped index back into coordinates
    assign cx = XW'(stack_q_reg % FRAME_WIDTH);
    assign cy = YW'(stack_q_reg / FRAME_WIDTH);

    // Current neighbour and its bounds check
    always_comb
    begin
        nx       = {1'b0, cx};
        ny       = {1'b0, cy};
        nb_valid = 1'b0;
        unique case (nb_reg)
            NB_RIGHT:
            begin
                nx       = {1'b0, cx} + 1'b1;
                nb_valid = int'(nx) < FRAME_WIDTH;
            end
            NB_LEFT:
            begin
                nx       = {1'b0, cx} - 1'b1;
                nb_valid = (cx != '0);
            end
            NB_DOWN:
            begin
                ny       = {1'b0, cy} + 1'b1;
                nb_valid = int'(ny) < FRAME_HEIGHT;
            end
            NB_UP:
            begin
                ny       = {1'b0, cy} - 1'b1;
                nb_valid = (cy != '0);
            end
        endcase
    end

    assign nb_addr = pix_index(nx, ny);

    // Frame port muxing
    assign pix_we    = (ctl.pix_wr_in && in_frame) || ctl.paint_seed || ctl.paint_nb;
    assign pix_waddr = ctl.paint_nb ? nb_addr : in_addr;
    assign pix_wdata = ctl.pix_wr_in ? pv_reg : fill_reg;
    assign pix_re    = ctl.pix_rd_in || ctl.pix_rd_nb;
    assign pix_raddr = ctl.pix_rd_nb ? nb_addr : in_addr;

    // Stack push shares the paint strobe
    assign push      = ctl.paint_seed || ctl.paint_nb;
    assign push_data = ctl.paint_nb ? nb_addr : in_addr;
    assign sp_dec    = sp_reg - 1'b1;

    // Frame store
    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            frame_mem[pix_waddr] <= pix_wdata;
        end
        if (pix_re)
        begin
            frame_q_reg <= frame_mem[pix_raddr];
        end
    end

    // Seed stack
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[sp_reg[STK_AW-1:0]] <= push_data;
        end
        if (ctl.pop)
        begin
            stack_q_reg <= stack_mem[sp_dec[STK_AW-1:0]];
        end
    end

    // Stack pointer, count and neighbour walk next values
    always_comb
    begin
        sp_next    = sp_reg;
        count_next = count_reg;
        nb_next    = nb_reg;
        priority if (ctl.paint_seed)
        begin
            sp_next    = SP_W'(1);
            count_next = CNT_W'(1);
        end
        else if (ctl.paint_nb)
        begin
            sp_next    = sp_reg + 1'b1;
            count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            sp_next = sp_dec;
        end
        else
        begin
            sp_next = sp_reg;
        end
        priority if (ctl.nb_clr)
        begin
            nb_next = NB_RIGHT;
        end
        else if (ctl.nb_inc)
        begin
            unique case (nb_reg)
                NB_RIGHT: nb_next = NB_LEFT;
                NB_LEFT:  nb_next = NB_DOWN;
                NB_DOWN:  nb_next = NB_UP;
                NB_UP:    nb_next = NB_UP;
            endcase
        end
        else
        begin
            nb_next = nb_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg    <= CMD_NOP;
            target_reg <= TARGET_RESET;
            fill_reg   <= FILL_RESET;
            sp_reg     <= '0;
            count_reg  <= '0;
            nb_reg     <= NB_RIGHT;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.latch)
            begin
                cmd_reg <= cmd_t'(cmd);
            end
            if (cfg_wr && (cfg_index == CFG_TARGET))
            begin
                target_reg <= cfg_data;
            end
            if (cfg_wr && (cfg_index == CFG_FILL))
            begin
                fill_reg <= cfg_data;
            end
            sp_reg    <= sp_next;
            count_reg <= count_next;
            nb_reg    <= nb_next;
            done_reg  <= ctl.res_read || ctl.res_fill || ctl.res_zero;
        end
    end

    // Command beat and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            x_reg  <= x_coord;
            y_reg  <= y_coord;
            pv_reg <= pixel_value;
        end
        if (ctl.res_read || ctl.res_fill || ctl.res_zero)
        begin
            rv_reg <= ctl.res_read ? frame_q_reg : '0;
            fc_reg <= ctl.res_fill ? count_reg : '0;
        end
    end

    // Status back to the sequencer
    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.in_frame     = in_frame;
        stat.colors_equal = (fill_reg == target_reg);
        stat.pix_match    = (frame_q_reg == target_reg);
        stat.nb_valid     = nb_valid;
        stat.nb_last      = (nb_reg == NB_UP);
        stat.sp_zero      = (sp_reg == '0);
        stat.sp_full      = (sp_reg == SP_W'(STACK_DEPTH));
    end

    assign done       = done_reg;
    assign read_value = rv_reg;
    assign fill_count = fc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/flood_fill_4_connected_unit.sv =====
// ============================================================================
// flood_fill_4_connected_unit : 4-connected seed flood fill engine
// Frame store of 24-bit RGB pixels with write, read and flood fill commands.
// A fill repaints every pixel reachable from the seed through up, down, left
// and right neighbours that holds the target color, using a coordinate stack.
//
//   channel   signals                                    direction  beat
//   command   start busy cmd x_coord y_coord pixel_value in         start & !busy
//   result    done read_value fill_count                 out        done
//   config    cfg_valid cfg_ready cfg_index cfg_data     in         cfg_valid & cfg_ready
//
// done is registered from the dispatch state for a write, a no-op, a fill with
// equal colors or an off-frame coordinate, from the wait state for a read, and
// from the seed check for an off-target seed. Any other fill passes dispatch and
// seed check, then for each painted pixel a pop state and, per neighbour, a read
// state plus a compare-and-paint state for an in-frame neighbour; a final pop
// issues the result. Neighbour reads share the single read port of the frame store.
// Reset clears the pointer and count and restores the default colors; the
// frame store is not cleared.
// busy stays high until the result is issued; done cannot be stalled.
// ============================================================================
`default_nettype none

module flood_fill_4_connected_unit
    import ff4_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // command
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           cmd,
    input  wire logic [XW-1:0]        x_coord,
    input  wire logic [YW-1:0]        y_coord,
    input  wire logic [COLOR_W-1:0]   pixel_value,
    // result
    output logic                      done,
    output logic [COLOR_W-1:0]        read_value,
    output logic [CNT_W-1:0]          fill_count,
    // configuration
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data
);

    ff4_ctrl_t ctl;
    ff4_stat_t stat;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    // Sequencer
    ff4_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Storage and arithmetic
    ff4_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .pixel_value (pixel_value),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ctl         (ctl),
        .stat        (stat),
        .done        (done),
        .read_value  (read_value),
        .fill_count  (fill_count)
    );

endmodule

`default_nettype wire
